FILE: rtl/radix_digit_converter_assert.svh
// Assertion macros for the radix digit converter.
// Each macro expects a clock named clk and an active low reset named rst_n in scope.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rdc_pkg.sv
// Shared constants, types and helper functions for the radix digit converter.
// No dependencies; the controller, datapath, top, checker and testbench import it, and the interfaces use its widths.
package rdc_pkg;

    localparam int VALUE_WIDTH        = 32;
    localparam int RADIX_WIDTH        = 6;
    localparam int CHAR_WIDTH         = 7;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_WIDTH-1:0]  ZERO_CHAR     = 7'd48;
    localparam logic [CHAR_WIDTH-1:0]  LETTER_BASE   = 7'd65;
    localparam logic [CHAR_WIDTH-1:0]  ERROR_CHAR    = 7'd0;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store_digit;
        logic read_digit;
        logic load_out;
        logic load_error;
    } rdc_cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic div_last;
        logic quot_zero;
        logic ptr_zero;
        logic out_free;
    } rdc_status_t;

    function automatic logic radix_valid(input logic [RADIX_WIDTH-1:0] radix);
        return (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] char_of(input logic [RADIX_WIDTH-1:0] digit);
        logic [CHAR_WIDTH-1:0] digit_ext;
        digit_ext = {1'b0, digit};
        if (digit < DECIMAL_LIMIT)
        begin
            return ZERO_CHAR + digit_ext;
        end
        return LETTER_BASE + digit_ext - {1'b0, DECIMAL_LIMIT};
    endfunction

endpackage

FILE: rtl/rdc_in_if.sv
// Request channel carrying a value and a base into the converter.
// Depends on rdc_pkg for the field widths.
interface rdc_in_if;
    logic                             valid;
    logic                             ready;
    logic [rdc_pkg::VALUE_WIDTH-1:0]  value;
    logic [rdc_pkg::RADIX_WIDTH-1:0]  radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink (input valid, input value, input radix, output ready);
endinterface

FILE: rtl/rdc_out_if.sv
// Result channel carrying one ASCII digit with its last and error flags.
// Depends on rdc_pkg for the field widths.
interface rdc_out_if;
    logic                            valid;
    logic                            ready;
    logic [rdc_pkg::CHAR_WIDTH-1:0]  digit_char;
    logic                            last;
    logic                            bad_radix;

    modport source (output valid, output digit_char, output last, output bad_radix, input ready);
    modport sink (input valid, input digit_char, input last, input bad_radix, output ready);
endinterface

FILE: rtl/rdc_controller.sv
// Sequencing state machine for the radix digit converter.
// Depends on rdc_pkg for the command and status structs.
module rdc_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rdc_pkg::rdc_status_t status,
    output rdc_pkg::rdc_cmd_t    cmd
);
    import rdc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DIGIT,
        ST_READ,
        ST_EMIT,
        ST_ERROR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.radix_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                cmd.store_digit = 1'b1;
                state_next      = status.quot_zero ? ST_READ : ST_DIVIDE;
            end
            ST_READ:
            begin
                cmd.read_digit = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = status.ptr_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_ERROR:
            begin
                if (status.out_free)
                begin
                    cmd.load_error = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/rdc_datapath.sv
// Datapath of the radix digit converter: bit-serial divider, digit store and
// output register. Depends on rdc_pkg; driven by rdc_controller commands.
module rdc_datapath #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0]  value,
    input  logic [rdc_pkg::RADIX_WIDTH-1:0]  radix,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [rdc_pkg::CHAR_WIDTH-1:0]   out_char,
    output logic                             out_last,
    output logic                             out_bad,
    input  rdc_pkg::rdc_cmd_t                cmd,
    output rdc_pkg::rdc_status_t             status
);
    import rdc_pkg::*;

    localparam int IW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]  quot_reg;
    logic [RADIX_WIDTH-1:0] base_reg;
    logic [RADIX_WIDTH-1:0] rem_reg;
    logic [IW-1:0]          bit_cnt_reg;
    logic [CW-1:0]          count_reg;
    logic [IW-1:0]          ptr_reg;
    logic [RADIX_WIDTH-1:0] rd_reg;
    logic                   out_valid_reg;
    logic [CHAR_WIDTH-1:0]  char_reg;
    logic                   last_reg;
    logic                   bad_reg;

    logic [RADIX_WIDTH-1:0] store_mem [VALUE_BITS];

    logic [RADIX_WIDTH:0]   trial;
    logic [RADIX_WIDTH:0]   diff;
    logic                   fits;
    logic [RADIX_WIDTH-1:0] rem_next;
    logic                   out_load;

    assign trial    = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff     = trial - {1'b0, base_reg};
    assign fits     = (trial >= {1'b0, base_reg});
    assign rem_next = fits ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
    assign out_load = cmd.load_out || cmd.load_error;

    assign status.radix_ok  = radix_valid(radix);
    assign status.div_last  = (bit_cnt_reg == IW'(VALUE_BITS - 1));
    assign status.quot_zero = (quot_reg == '0);
    assign status.ptr_zero  = (ptr_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_bad   = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                quot_reg  <= VALUE_BITS'(value);
                count_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                quot_reg <= {quot_reg[VALUE_BITS-2:0], fits};
            end
            else if (cmd.store_digit)
            begin
                count_reg <= count_reg + CW'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg    <= radix;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + IW'(1);
        end
        else if (cmd.store_digit)
        begin
            store_mem[count_reg[IW-1:0]] <= rem_reg;
            ptr_reg                      <= count_reg[IW-1:0];
            rem_reg                      <= '0;
            bit_cnt_reg                  <= '0;
        end
        else if (cmd.load_out)
        begin
            ptr_reg <= ptr_reg - IW'(1);
        end

        if (cmd.read_digit)
        begin
            rd_reg <= store_mem[ptr_reg];
        end

        if (cmd.load_out)
        begin
            char_reg <= char_of(rd_reg);
            last_reg <= status.ptr_zero;
            bad_reg  <= 1'b0;
        end
        else if (cmd.load_error)
        begin
            char_reg <= ERROR_CHAR;
            last_reg <= 1'b1;
            bad_reg  <= 1'b1;
        end
    end

endmodule

FILE: rtl/radix_digit_converter.sv
// Radix digit converter: turns an unsigned value into ASCII digits of a base.
// Each request on operand carries value and radix; results leave on digits as
// one character per transfer, most significant digit first, last set on the
// final character. A value of zero gives the single character '0'. A radix
// outside 2 to 36 gives one result with digit_char zero, last and bad_radix set.
// Each digit is found by the one-bit-per-cycle divider, which shifts through
// the whole quotient and then writes the remainder to the digit store; each
// character is then read from the store and loaded into the output register.
// A bad radix sends the state machine to its error state, which loads the
// error result into the output register once that register is free.
// A new request is taken once the previous conversion has loaded its final
// character, even while that character still waits in the output register.
// If the receiver stalls, emission pauses with the pending character held.
// Reset clears the state machine, the output valid, the quotient and the count;
// the digit store needs no clearing because each conversion writes before reading.
// Depends on rdc_pkg, rdc_in_if, rdc_out_if, rdc_controller, rdc_datapath and
// radix_digit_converter_assert.svh.
module radix_digit_converter #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    rdc_in_if.sink    operand,
    rdc_out_if.source digits
);
    import rdc_pkg::*;

    `include "radix_digit_converter_assert.svh"

    rdc_cmd_t    cmd;
    rdc_status_t status;
    logic        in_ready;

    assign operand.ready = in_ready;

    rdc_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rdc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (operand.value),
        .radix     (operand.radix),
        .out_ready (digits.ready),
        .out_valid (digits.valid),
        .out_char  (digits.digit_char),
        .out_last  (digits.last),
        .out_bad   (digits.bad_radix),
        .cmd       (cmd),
        .status    (status)
    );

    `RDC_ASSERT_NEXT(busy_after_request, operand.valid && operand.ready, !operand.ready,
        "request accepted while a conversion was still running")
    `RDC_ASSERT_SAME(no_overwrite_on_stall, digits.valid && !digits.ready,
        !cmd.load_out && !cmd.load_error, "output register overwritten during a stall")
    `RDC_ASSERT_SAME(error_result_form, digits.valid && digits.bad_radix,
        digits.last && (digits.digit_char == ERROR_CHAR), "malformed bad radix result")
    `RDC_ASSERT_NEXT(bad_radix_goes_to_error, operand.valid && operand.ready && !status.radix_ok,
        !cmd.div_step && !cmd.store_digit, "divider started for a bad radix")

endmodule

FILE: test/radix_digit_checker.sv
`timescale 1ns / 1ps
// Checker for the radix digit converter: watches the request and digit channels,
// predicts the ASCII digits of every accepted request and compares them in order.
// Depends on rdc_pkg, rdc_in_if and rdc_out_if.
module radix_digit_checker (
    input  logic        clk,
    input  logic        rst_n,
    rdc_in_if           operand,
    rdc_out_if          digits,
    output int unsigned failures,
    output int unsigned pending,
    output int unsigned results_seen
);
    import rdc_pkg::*;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] digit_char;
        logic                  last;
        logic                  bad_radix;
    } digit_result_t;

    digit_result_t expected_chars[$];

    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_WIDTH-1:0] remainders [VALUE_WIDTH];

    function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] v,
                                           input logic [RADIX_WIDTH-1:0] r);
        digit_result_t res;
        int n;
        int k;
        n = 0;
        if (r < RADIX_MIN || r > RADIX_MAX)
        begin
            res = '{ERROR_CHAR, 1'b1, 1'b1};
            expected_chars.push_back(res);
            return;
        end
        quotient = v;
        do
        begin
            remainders[n] = RADIX_WIDTH'(quotient % r);
            n++;
            quotient = quotient / r;
        end
        while (quotient != 0);
        for (k = n - 1; k >= 0; k--)
        begin
            if (remainders[k] < DECIMAL_LIMIT)
                res.digit_char = ZERO_CHAR + CHAR_WIDTH'(remainders[k]);
            else
                res.digit_char = LETTER_BASE + CHAR_WIDTH'(remainders[k] - DECIMAL_LIMIT);
            res.last = (k == 0);
            res.bad_radix = 1'b0;
            expected_chars.push_back(res);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        digit_result_t got;
        digit_result_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            quotient = '0;
            failures = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (operand.valid && operand.ready)
                predict_digits(operand.value, operand.radix);
            if (digits.valid && digits.ready)
            begin
                got = '{digits.digit_char, digits.last, digits.bad_radix};
                results_seen++;
                if (expected_chars.size() == 0)
                begin
                    failures++;
                    if (failures <= 50)
                        $display("%0t: unexpected digit char=%0d last=%0b bad_radix=%0b",
                                 $time, got.digit_char, got.last, got.bad_radix);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (got.digit_char !== want.digit_char || got.last !== want.last ||
                        got.bad_radix !== want.bad_radix)
                    begin
                        failures++;
                        if (failures <= 50)
                            $display("%0t: mismatch, expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     $time, want.digit_char, want.last, want.bad_radix,
                                     got.digit_char, got.last, got.bad_radix);
                    end
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

FILE: test/tb_radix_digit_converter.sv
`timescale 1ns / 1ps
// Top of the radix digit converter testbench: clock, reset, request stimulus and
// digit back-pressure, with the verdict taken from radix_digit_checker.
// Depends on rdc_pkg, rdc_in_if, rdc_out_if, radix_digit_converter and the checker.
module tb_radix_digit_converter;
    import rdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 4_000_000;
    localparam int unsigned RANDOM_REQUESTS = 310;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int unsigned failures;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned requests_sent = 0;
    int unsigned bad_requests = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_hold;
    bit          steady_source = 1'b0;

    rdc_in_if  operand_ch ();
    rdc_out_if digits_ch ();

    radix_digit_converter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .digits  (digits_ch)
    );

    radix_digit_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .operand      (operand_ch),
        .digits       (digits_ch),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d digits outstanding.", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [VALUE_WIDTH-1:0] v,
                                input logic [RADIX_WIDTH-1:0] r);
        int unsigned gap;
        gap = steady_source ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            operand_ch.valid <= 1'b0;
            operand_ch.value <= $urandom;
            operand_ch.radix <= RADIX_WIDTH'($urandom);
            repeat (gap) @(negedge clk);
        end
        operand_ch.valid <= 1'b1;
        operand_ch.value <= v;
        operand_ch.radix <= r;
        do
            @(posedge clk);
        while (!operand_ch.ready);
        requests_sent++;
        if (r < RADIX_MIN || r > RADIX_MAX)
            bad_requests++;
    endtask

    initial
    begin
        int unsigned roll;
        digits_ch.ready = 1'b0;
        ready_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
                ready_hold--;
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6)
                begin
                    digits_ch.ready <= 1'b1;
                    ready_hold = $urandom_range(0, 11);
                end
                else if (roll < 8)
                begin
                    digits_ch.ready <= 1'b1;
                    ready_hold = $urandom_range(50, 300);
                end
                else
                begin
                    digits_ch.ready <= 1'b0;
                    ready_hold = pick_gap();
                end
            end
        end
    end

    initial
    begin
        int unsigned            i;
        int unsigned            roll;
        logic [VALUE_WIDTH-1:0] v;
        logic [RADIX_WIDTH-1:0] r;

        operand_ch.valid = 1'b0;
        operand_ch.value = '0;
        operand_ch.radix = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_request(32'd0, 6'd10);
        send_request(32'd0, RADIX_MIN);
        send_request(32'd0, RADIX_MAX);
        send_request(32'hFFFF_FFFF, RADIX_MIN);
        send_request(32'hFFFF_FFFF, RADIX_MAX);
        send_request(32'hFFFF_FFFF, 6'd10);
        send_request(32'h8000_0000, RADIX_MIN);
        send_request(32'd1, RADIX_MIN);
        send_request(32'd35, RADIX_MAX);
        send_request(32'd36, RADIX_MAX);
        send_request(32'd10, 6'd16);
        send_request(32'd255, 6'd16);
        send_request(32'd12345, 6'd10);
        send_request(32'hDEAD_BEEF, 6'd16);
        send_request(32'd100, 6'd3);
        send_request(32'd35, 6'd35);
        send_request(32'h5555_5555, 6'd4);
        send_request(32'hAAAA_AAAA, 6'd8);
        send_request(32'd5, 6'd0);
        send_request(32'd5, 6'd1);
        send_request(32'd5, 6'd37);
        send_request(32'hFFFF_FFFF, 6'd63);
        send_request(32'd0, 6'd0);
        send_request(32'd48, 6'd7);

        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 32 == 0)
                steady_source = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 8)
                r = $urandom_range(0, 1) ? RADIX_WIDTH'($urandom_range(0, 1))
                                         : RADIX_WIDTH'($urandom_range(37, 63));
            else if (roll < 18)
                r = $urandom_range(0, 1) ? RADIX_MIN : RADIX_MAX;
            else
                r = RADIX_WIDTH'($urandom_range(2, 36));
            roll = $urandom_range(0, 99);
            if (roll < 8)
                v = '0;
            else if (roll < 16)
                v = 32'hFFFF_FFFF - VALUE_WIDTH'($urandom_range(0, 3));
            else if (roll < 46)
                v = VALUE_WIDTH'($urandom_range(0, 999));
            else
                v = $urandom;
            send_request(v, r);
        end

        @(negedge clk);
        operand_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Converted %0d requests, %0d of them with a base outside 2 to 36.",
                 requests_sent, bad_requests);
        $display("Checked %0d digit results under random source gaps and sink stalls.",
                 results_seen);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rdc_pkg.sv
rtl/rdc_in_if.sv
rtl/rdc_out_if.sv
rtl/rdc_controller.sv
rtl/rdc_datapath.sv
rtl/radix_digit_converter.sv
test/radix_digit_checker.sv
test/tb_radix_digit_converter.sv
